>>> rtl/core/dis_pkg.sv
// shared types, widths and constants for the dynamic inoperability step engine
// no dependencies; compiled first
package dis_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int VAL_W      = 18;
  localparam int ROW_W      = 4;
  localparam int STEP_W     = 16;
  localparam int CFG_SC_W   = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [Q_W-1:0]      ONE      = Q_W'(1) << FRAC_BITS;
  localparam logic [CFG_SC_W-1:0] SC_RESET = CFG_SC_W'(16);

  typedef enum logic [1:0] {
    FUNC_MATRIX = 2'd0,
    FUNC_GAIN   = 2'd1,
    FUNC_QINIT  = 2'd2,
    FUNC_PERT   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYSTEM_COUNT = 1'b0,
    CFG_STEP_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic brk_en;
    logic mul_gain;
  } alu_ctrl_t;

  // saturate a loaded vector value to [0, 1.0]
  function automatic logic [Q_W-1:0] clamp_load(input logic signed [VAL_W-1:0] v);
    logic [Q_W-1:0] r;
    if (v[VAL_W-1]) begin
      r = '0;
    end else if ($unsigned(v) > VAL_W'(ONE)) begin
      r = ONE;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/dis_if.sv
// request channels of the step engine: input items and result items
// depends on dis_pkg
interface dis_in_if;
  logic                                valid;
  logic                                ready;
  dis_pkg::func_e                      func;
  logic [dis_pkg::ROW_W-1:0]           row_index;
  logic [dis_pkg::ROW_W-1:0]           col_index;
  logic signed [dis_pkg::VAL_W-1:0]    value;

  modport source (output valid, func, row_index, col_index, value, input ready);
  modport sink   (input valid, func, row_index, col_index, value, output ready);
endinterface

interface dis_out_if;
  logic                          valid;
  logic                          ready;
  logic [dis_pkg::ROW_W-1:0]     system_index;
  logic [dis_pkg::Q_W-1:0]       inoperability;
  logic [dis_pkg::STEP_W-1:0]    step_number;
  logic                          last;

  modport source (output valid, system_index, inoperability, step_number, last, input ready);
  modport sink   (input valid, system_index, inoperability, step_number, last, output ready);
endinterface

>>> rtl/core/dis_alu.sv
// shared multiply unit with accumulator, bracket register and final clamp
// depends on dis_pkg
module dis_alu #(
  parameter int MAX_SYSTEMS = 16
) (
  input  logic                             clk_i,
  input  dis_pkg::alu_ctrl_t               ctrl_i,
  input  logic signed [dis_pkg::VAL_W-1:0] mat_i,
  input  logic [dis_pkg::Q_W-1:0]          q_op_i,
  input  logic [dis_pkg::Q_W-1:0]          k_i,
  input  logic [dis_pkg::Q_W-1:0]          c_i,
  input  logic [dis_pkg::Q_W-1:0]          q_i,
  output logic [dis_pkg::Q_W-1:0]          q_next_o
);
  import dis_pkg::*;

  localparam int PROD0_W = 2 * VAL_W - 1;
  localparam int ACC_W   = PROD0_W + $clog2(MAX_SYSTEMS);
  localparam int FLR_W   = ACC_W - FRAC_BITS;
  localparam int BR_W    = FLR_W + 2;
  localparam int P_W     = VAL_W + BR_W;
  localparam int G_W     = P_W - FRAC_BITS;
  localparam int S_W     = G_W + 1;

  logic signed [VAL_W-1:0] mul_a;
  logic signed [BR_W-1:0]  mul_b;
  logic signed [P_W-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [BR_W-1:0]  brk_q;
  logic signed [BR_W-1:0]  brk_d;
  logic [Q_W-1:0]          kop_q;
  logic signed [FLR_W-1:0] flr;
  logic signed [G_W-1:0]   gp;
  logic signed [S_W-1:0]   sum;

  assign mul_a = ctrl_i.mul_gain ? signed'({1'b0, kop_q}) : mat_i;
  assign mul_b = ctrl_i.mul_gain ? brk_q : BR_W'(signed'({1'b0, q_op_i}));

  // floor of the row sum to the q fraction
  assign flr   = acc_q[ACC_W-1:FRAC_BITS];
  assign brk_d = BR_W'(flr) + BR_W'(signed'({1'b0, c_i})) - BR_W'(signed'({1'b0, q_i}));

  assign gp  = prod_q[P_W-1:FRAC_BITS];
  assign sum = S_W'(gp) + S_W'(signed'({1'b0, q_i}));

  always_comb begin
    if (sum[S_W-1]) begin
      q_next_o = '0;
    end else if (sum > S_W'(ONE)) begin
      q_next_o = ONE;
    end else begin
      q_next_o = sum[Q_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctrl_i.brk_en) begin
      brk_q <= brk_d;
      kop_q <= k_i;
    end
  end

endmodule

>>> rtl/core/dynamic_inoperability_step.sv
// Dynamic inoperability step engine. Matrix, gain, initial q and perturbation
// entries are loaded one request each. The perturbation request for system n-1
// fires a time step (if the step number stays below step_limit): one shared
// multiplier fed by the single read port of the coupling matrix memory does all
// products, row by row, and an output stall lengthens a step. Results leave
// through an output register; the block takes no request while a step is being
// computed or its results are being emitted. The coupling matrix and
// perturbation buffer have no reset and must be written before a step reads
// them.
// depends on dis_pkg, dis_if and dis_alu
module dynamic_inoperability_step #(
  parameter int MAX_SYSTEMS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  dis_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [dis_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  dis_in_if.sink                          in_i,
  dis_out_if.source                       out_o
);
  import dis_pkg::*;

  localparam int IDX_W     = $clog2(MAX_SYSTEMS);
  localparam int CNT_W     = $clog2(MAX_SYSTEMS + 1);
  localparam int MAT_DEPTH = 1 << (2 * IDX_W);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MAC    = 7'b0000010,
    ST_BRK    = 7'b0000100,
    ST_GMUL   = 7'b0001000,
    ST_UPD    = 7'b0010000,
    ST_COMMIT = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_SC_W-1:0] sc_q;
  logic [STEP_W-1:0]   sl_q;
  logic [STEP_W-1:0]   step_q;
  logic [STEP_W-1:0]   t_q;
  logic [IDX_W-1:0]    i_q;
  logic [IDX_W-1:0]    e_q;
  logic [CNT_W-1:0]    j_q;
  logic                v1_q;
  logic                v2_q;

  logic [Q_W-1:0] k_q  [MAX_SYSTEMS];
  logic [Q_W-1:0] q_q  [MAX_SYSTEMS];
  logic [Q_W-1:0] c_q  [MAX_SYSTEMS];
  logic [Q_W-1:0] nq_q [MAX_SYSTEMS];

  logic signed [VAL_W-1:0] mat_mem [MAT_DEPTH];
  logic signed [VAL_W-1:0] rdata_q;
  logic [Q_W-1:0]          qop_q;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_idx_q;
  logic [Q_W-1:0]    out_inop_q;
  logic [STEP_W-1:0] out_step_q;
  logic              out_last_q;

  logic             in_acc;
  logic             row_ok;
  logic             col_ok;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;
  logic [CNT_W-1:0] n;
  logic [STEP_W:0]  step_inc;
  logic             fire;
  logic             mat_we;
  logic             issue;
  logic             mac_done;
  logic             row_last;
  logic             emit_ld;
  logic             emit_last;
  logic [IDX_W-1:0] q_idx;
  logic [Q_W-1:0]   q_rd;
  logic [Q_W-1:0]   load_val;
  logic [Q_W-1:0]   q_next;
  alu_ctrl_t        ctrl;

  always_comb begin
    if (sc_q == '0) begin
      n = CNT_W'(1);
    end else if (32'(sc_q) > MAX_SYSTEMS) begin
      n = CNT_W'(MAX_SYSTEMS);
    end else begin
      n = CNT_W'(sc_q);
    end
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign row_ok   = 32'(in_i.row_index) < MAX_SYSTEMS;
  assign col_ok   = 32'(in_i.col_index) < MAX_SYSTEMS;
  assign row_idx  = IDX_W'(in_i.row_index);
  assign col_idx  = IDX_W'(in_i.col_index);
  assign load_val = clamp_load(in_i.value);
  assign step_inc = {1'b0, step_q} + (STEP_W + 1)'(1);
  assign mat_we   = in_acc && row_ok && col_ok && (in_i.func == FUNC_MATRIX);
  assign fire     = in_acc && row_ok && (in_i.func == FUNC_PERT)
                    && (32'(in_i.row_index) == 32'(n) - 1)
                    && (step_inc < {1'b0, sl_q});

  assign issue     = (state_q == ST_MAC) && (j_q < n);
  assign mac_done  = (state_q == ST_MAC) && (j_q == n) && !v1_q && !v2_q;
  assign row_last  = CNT_W'(i_q) == (n - CNT_W'(1));
  assign emit_ld   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign emit_last = CNT_W'(e_q) == (n - CNT_W'(1));

  // one read port on the q vector, shared by the row sum, the update and the output
  always_comb begin
    unique case (state_q)
      ST_MAC:  q_idx = j_q[IDX_W-1:0];
      ST_EMIT: q_idx = e_q;
      default: q_idx = i_q;
    endcase
  end
  assign q_rd = q_q[q_idx];

  assign ctrl.acc_clr  = fire || ((state_q == ST_UPD) && !row_last);
  assign ctrl.acc_en   = v2_q;
  assign ctrl.brk_en   = (state_q == ST_BRK);
  assign ctrl.mul_gain = (state_q == ST_GMUL);

  dis_alu #(
    .MAX_SYSTEMS (MAX_SYSTEMS)
  ) u_alu (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .mat_i    (rdata_q),
    .q_op_i   (qop_q),
    .k_i      (k_q[i_q]),
    .c_i      (c_q[i_q]),
    .q_i      (q_rd),
    .q_next_o (q_next)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (fire) state_d = ST_MAC;
      ST_MAC:    if (mac_done) state_d = ST_BRK;
      ST_BRK:    state_d = ST_GMUL;
      ST_GMUL:   state_d = ST_UPD;
      ST_UPD:    state_d = row_last ? ST_COMMIT : ST_MAC;
      ST_COMMIT: state_d = ST_EMIT;
      ST_EMIT:   if (emit_ld && emit_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sc_q        <= SC_RESET;
      sl_q        <= '0;
      step_q      <= '0;
      t_q         <= '0;
      i_q         <= '0;
      e_q         <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SYSTEM_COUNT: sc_q <= cfg_data_i[CFG_SC_W-1:0];
          CFG_STEP_LIMIT:   sl_q <= cfg_data_i[STEP_W-1:0];
          default:          ;
        endcase
      end
      if (in_acc && row_ok && (in_i.func == FUNC_QINIT)) begin
        step_q <= '0;
      end
      if (fire) begin
        t_q <= step_inc[STEP_W-1:0];
        i_q <= '0;
        j_q <= '0;
      end
      // read, multiply, accumulate pipeline for the row sum
      v1_q <= issue;
      v2_q <= v1_q;
      if (issue) begin
        j_q <= j_q + CNT_W'(1);
      end
      if ((state_q == ST_UPD) && !row_last) begin
        i_q <= i_q + IDX_W'(1);
        j_q <= '0;
      end
      if (state_q == ST_COMMIT) begin
        e_q    <= '0;
        step_q <= t_q;
      end
      if (emit_ld) begin
        e_q         <= e_q + IDX_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // coupling matrix: one write port for loads, one registered read port for the row sum
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[{row_idx, col_idx}] <= in_i.value;
    end
    rdata_q <= mat_mem[{i_q, j_q[IDX_W-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      qop_q <= q_rd;
    end
    if (state_q == ST_UPD) begin
      nq_q[i_q] <= q_next;
    end
    if (in_acc && row_ok && (in_i.func == FUNC_PERT)) begin
      c_q[row_idx] <= load_val;
    end
    if (emit_ld) begin
      out_idx_q  <= ROW_W'(e_q);
      out_inop_q <= q_rd;
      out_step_q <= t_q;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SYSTEMS; k++) begin
        k_q[k] <= ONE;
        q_q[k] <= '0;
      end
    end else begin
      if (in_acc && row_ok && (in_i.func == FUNC_GAIN)) begin
        k_q[row_idx] <= load_val;
      end
      if (in_acc && row_ok && (in_i.func == FUNC_QINIT)) begin
        q_q[row_idx] <= load_val;
      end
      // new vector replaces the old one only after every row used the old one
      if (state_q == ST_COMMIT) begin
        for (int k = 0; k < MAX_SYSTEMS; k++) begin
          if (k < int'(n)) begin
            q_q[k] <= nq_q[k];
          end
        end
      end
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.system_index  = out_idx_q;
  assign out_o.inoperability = out_inop_q;
  assign out_o.step_number   = out_step_q;
  assign out_o.last          = out_last_q;

endmodule

>>> sim/dynamic_inoperability_step_tb.sv
// self-checking testbench for the dynamic inoperability step engine: a queue-fed request
// driver, a stalling result monitor and a bit-exact predictor of every time step
// depends on dis_pkg, dis_if and the dynamic_inoperability_step rtl
`timescale 1ns / 1ps

module dynamic_inoperability_step_tb;
  import dis_pkg::*;

  localparam int NSYS       = 16;
  localparam int SETTLE     = 24;
  localparam int BULK_ITEMS = 170;

  typedef struct {
    func_e                   func;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } step_req_t;

  typedef struct {
    logic [ROW_W-1:0]  system_index;
    logic [Q_W-1:0]    level;
    logic [STEP_W-1:0] step_number;
    logic              last;
  } level_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dis_in_if  req_bus ();
  dis_out_if res_bus ();

  dynamic_inoperability_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_bus),
    .out_o      (res_bus)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  longint      coupling [NSYS][NSYS];
  longint      gain_k [NSYS];
  longint      level_q [NSYS];
  longint      pert_c [NSYS];
  int unsigned steps_done     = 0;
  int unsigned sys_count_reg  = 16;
  int unsigned step_limit_reg = 0;

  level_t      expected_levels [$];
  step_req_t   load_queue [$];
  int unsigned errors = 0;

  // stimulus planning state
  int unsigned plan_n     = NSYS;
  int unsigned plan_limit = 0;
  int unsigned bulk_sent  = 0;
  bit          a_set [NSYS][NSYS];
  bit          c_set [NSYS];
  bit          no_idle    = 1'b0;

  int unsigned req_issued = 0;
  int unsigned req_taken  = 0;
  int unsigned req_wait   = 0;
  int unsigned res_taken  = 0;
  int unsigned res_seen   = 0;
  int unsigned res_wait   = 0;

  function automatic longint unit_clamp(longint x);
    if (x < 0) return 0;
    if (x > longint'(ONE)) return longint'(ONE);
    return x;
  endfunction

  function automatic int unsigned active_systems(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > NSYS) return NSYS;
    return raw;
  endfunction

  function automatic int unsigned pick_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // one accepted request: update state, queue the new q vector when a step fires
  task automatic advance_inoperability(step_req_t r);
    int unsigned n;
    int unsigned t;
    int unsigned i;
    int unsigned j;
    longint      acc;
    longint      brk;
    longint      nxt [NSYS];
    level_t      e;
    n = active_systems(sys_count_reg);
    case (r.func)
      FUNC_MATRIX: coupling[r.row][r.col] = longint'(r.value);
      FUNC_GAIN:   gain_k[r.row] = unit_clamp(longint'(r.value));
      FUNC_QINIT: begin
        level_q[r.row] = unit_clamp(longint'(r.value));
        steps_done = 0;
      end
      default: begin
        pert_c[r.row] = unit_clamp(longint'(r.value));
        t = steps_done + 1;
        if (r.row == n - 1 && t < step_limit_reg) begin
          for (i = 0; i < n; i++) begin
            acc = 0;
            for (j = 0; j < n; j++) acc += coupling[i][j] * level_q[j];
            // arithmetic shifts floor toward minus infinity
            brk = (acc >>> FRAC_BITS) + pert_c[i] - level_q[i];
            nxt[i] = unit_clamp(level_q[i] + ((gain_k[i] * brk) >>> FRAC_BITS));
          end
          for (i = 0; i < n; i++) begin
            level_q[i] = nxt[i];
            e.system_index = ROW_W'(i);
            e.level = Q_W'(nxt[i]);
            e.step_number = STEP_W'(t);
            e.last = (i == n - 1);
            expected_levels = {expected_levels, e};
          end
          steps_done = t & 16'hFFFF;
        end
      end
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] draw_value(func_e f);
    logic signed [VAL_W-1:0] v;
    if ($urandom_range(0, 5) == 0) begin
      v = VAL_W'($urandom());
    end else if (f == FUNC_MATRIX) begin
      v = VAL_W'(int'($urandom_range(0, 65536)) - 32768);
    end else begin
      v = VAL_W'($urandom_range(0, ONE));
    end
    return v;
  endfunction

  function automatic int unsigned pick_row();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, NSYS - 1);
    return $urandom_range(0, plan_n - 1);
  endfunction

  function automatic void queue_req(func_e f, int unsigned row, int unsigned col,
                                    logic signed [VAL_W-1:0] v);
    step_req_t r;
    r.func  = f;
    r.row   = ROW_W'(row);
    r.col   = ROW_W'(col);
    r.value = v;
    load_queue = {load_queue, r};
    bulk_sent++;
    if (f == FUNC_MATRIX) a_set[row][col] = 1'b1;
    if (f == FUNC_PERT) c_set[row] = 1'b1;
  endfunction

  function automatic void send(func_e f, int unsigned row, int unsigned col,
                               logic signed [VAL_W-1:0] v);
    int unsigned i;
    int unsigned j;
    // a step that may fire reads every active matrix entry and perturbation
    if (f == FUNC_PERT && row == plan_n - 1 && plan_limit > 1) begin
      for (i = 0; i < plan_n; i++) begin
        for (j = 0; j < plan_n; j++) begin
          if (!a_set[i][j]) queue_req(FUNC_MATRIX, i, j, draw_value(FUNC_MATRIX));
        end
      end
      for (i = 0; i + 1 < plan_n; i++) begin
        if (!c_set[i]) queue_req(FUNC_PERT, i, 0, draw_value(FUNC_PERT));
      end
    end
    queue_req(f, row, col, v);
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (load_queue.size() != 0 || req_bus.valid || expected_levels.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_DATA_W'(data);
    if (idx == CFG_SYSTEM_COUNT) sys_count_reg = data & 32'h1F;
    else step_limit_reg = data & 32'hFFFF;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic configure(int unsigned raw_count, int unsigned limit);
    wait_idle();
    write_reg(CFG_SYSTEM_COUNT, raw_count);
    write_reg(CFG_STEP_LIMIT, limit);
    plan_n     = active_systems(raw_count & 32'h1F);
    plan_limit = limit;
  endtask

  task automatic random_phase(int unsigned budget);
    int unsigned stop;
    int unsigned i;
    func_e       f;
    stop = bulk_sent + budget;
    while (bulk_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          f = func_e'($urandom_range(0, 3));
          send(f, $urandom_range(0, 15), $urandom_range(0, 15), draw_value(f));
        end
        2: send(FUNC_GAIN, pick_row(), $urandom_range(0, 15), draw_value(FUNC_GAIN));
        3: send(FUNC_QINIT, pick_row(), $urandom_range(0, 15), draw_value(FUNC_QINIT));
        4: send(FUNC_MATRIX, pick_row(), pick_row(), draw_value(FUNC_MATRIX));
        default: begin
          // perturbation vector, some elements refreshed, closed by the trigger row
          for (i = 0; i + 1 < plan_n; i++) begin
            if ($urandom_range(0, 1) == 1) begin
              send(FUNC_PERT, i, $urandom_range(0, 15), draw_value(FUNC_PERT));
            end
          end
          send(FUNC_PERT, plan_n - 1, $urandom_range(0, 15), draw_value(FUNC_PERT));
        end
      endcase
    end
  endtask

  // request driver
  always @(negedge clk_i) begin : drive_requests
    step_req_t nxt;
    if (rst_ni && !(req_bus.valid && req_taken != req_issued)) begin
      if (req_wait != 0) begin
        req_wait = req_wait - 1;
        req_bus.valid <= 1'b0;
      end else if (load_queue.size() != 0) begin
        nxt = load_queue.pop_front();
        req_bus.valid     <= 1'b1;
        req_bus.func      <= nxt.func;
        req_bus.row_index <= nxt.row;
        req_bus.col_index <= nxt.col;
        req_bus.value     <= nxt.value;
        req_issued++;
        req_wait = pick_wait();
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : capture_requests
    step_req_t r;
    if (rst_ni && req_bus.valid && req_bus.ready) begin
      r.func  = req_bus.func;
      r.row   = req_bus.row_index;
      r.col   = req_bus.col_index;
      r.value = req_bus.value;
      advance_inoperability(r);
      req_taken <= req_taken + 1;
    end
  end

  // result backpressure
  always @(negedge clk_i) begin : pace_results
    if (rst_ni) begin
      if (res_taken != res_seen) begin
        res_seen = res_taken;
        res_wait = pick_wait();
      end
      if (res_wait != 0) begin
        res_wait = res_wait - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    level_t e;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      res_taken <= res_taken + 1;
      if (expected_levels.size() == 0) begin
        errors++;
        $error("unexpected result: system_index %0d inoperability %0d step_number %0d",
               res_bus.system_index, res_bus.inoperability, res_bus.step_number);
      end else begin
        e = expected_levels.pop_front();
        if (res_bus.system_index !== e.system_index) begin
          errors++;
          $error("system_index: expected %0d, got %0d", e.system_index,
                 res_bus.system_index);
        end
        if (res_bus.inoperability !== e.level) begin
          errors++;
          $error("inoperability: expected %0d, got %0d", e.level, res_bus.inoperability);
        end
        if (res_bus.step_number !== e.step_number) begin
          errors++;
          $error("step_number: expected %0d, got %0d", e.step_number,
                 res_bus.step_number);
        end
        if (res_bus.last !== e.last) begin
          errors++;
          $error("last: expected %0d, got %0d", e.last, res_bus.last);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned base;
    int unsigned raw;
    int unsigned limit;
    int unsigned k;
    req_bus.valid     = 1'b0;
    req_bus.func      = FUNC_MATRIX;
    req_bus.row_index = '0;
    req_bus.col_index = '0;
    req_bus.value     = '0;
    res_bus.ready     = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_SYSTEM_COUNT;
    cfg_data          = '0;
    for (i = 0; i < NSYS; i++) begin
      gain_k[i]  = longint'(ONE);
      level_q[i] = 0;
      pert_c[i]  = 0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: 16 systems and limit 0, so the trigger row only stores
    send(FUNC_GAIN, 0, 0, -131072);
    send(FUNC_GAIN, 15, 15, 131071);
    send(FUNC_QINIT, 3, 0, 65537);
    send(FUNC_QINIT, 0, 0, 0);
    send(FUNC_PERT, 15, 0, -1);

    // two systems, extreme couplings, zero gain on row 0, floors on negative sums
    configure(2, 65535);
    send(FUNC_MATRIX, 0, 0, 131071);
    send(FUNC_MATRIX, 0, 1, -131072);
    send(FUNC_MATRIX, 1, 0, -32769);
    send(FUNC_MATRIX, 1, 1, 65536);
    send(FUNC_GAIN, 1, 0, 40000);
    send(FUNC_QINIT, 0, 0, 65536);
    send(FUNC_QINIT, 1, 0, 12345);
    send(FUNC_PERT, 0, 0, 0);
    send(FUNC_PERT, 1, 0, 65536);
    send(FUNC_PERT, 1, 0, 100);
    send(FUNC_PERT, 0, 0, 777);
    send(FUNC_MATRIX, 15, 15, -1);
    send(FUNC_PERT, 9, 0, 131071);
    send(FUNC_QINIT, 1, 0, 5);
    send(FUNC_PERT, 1, 0, 30000);

    // count 0 saturates to one system; limit 3 stops the third step until a q reload
    configure(0, 3);
    send(FUNC_PERT, 0, 0, 20000);
    send(FUNC_PERT, 0, 0, 40000);
    send(FUNC_PERT, 0, 0, 65536);
    send(FUNC_QINIT, 0, 0, 30000);
    send(FUNC_PERT, 0, 0, 1000);

    base = bulk_sent;
    while (bulk_sent - base < BULK_ITEMS) begin
      k = $urandom_range(0, 9);
      raw = (k == 0) ? 0 : (k < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      case ($urandom_range(0, 7))
        0:       limit = 0;
        1:       limit = 1;
        2, 3:    limit = $urandom_range(2, 6);
        4:       limit = $urandom_range(7, 65535);
        default: limit = 65535;
      endcase
      configure(raw, limit);
      no_idle = ($urandom_range(0, 3) == 0);
      random_phase($urandom_range(15, 35));
    end

    // full size once: count 31 saturates to all systems, limit 1 keeps triggers store-only
    configure(31, 1);
    no_idle = 1'b0;
    random_phase(20);
    for (i = 0; i < 2; i++) send(FUNC_PERT, NSYS - 1, 0, draw_value(FUNC_PERT));

    wait_idle();
    if (errors == 0) begin
      $display("dynamic_inoperability_step regression: pass");
    end else begin
      $display("dynamic_inoperability_step regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("dynamic_inoperability_step regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dis_pkg.sv
rtl/core/dis_if.sv
rtl/core/dis_alu.sv
rtl/core/dynamic_inoperability_step.sv
sim/dynamic_inoperability_step_tb.sv
